@@ rtl/ospm_pkg.sv @@
// Package with shared types, constants and helpers for the oversleep margin block.
`timescale 1ns / 1ps
package ospm_pkg;

   localparam int DEFAULT_DEPTH = 128;
   localparam logic [31:0] SIGN_BIAS = 32'h8000_0000;
   localparam int REFRESH_EVERY = 32;
   localparam int MIN_FOR_MODEL = 8;

   localparam logic [1:0] CSR_TICKS_PER_US = 2'd0;
   localparam logic [1:0] CSR_FIXED_MARGIN = 2'd1;
   localparam logic [1:0] CSR_PERIOD_HINT = 2'd2;

   localparam logic [1:0] MODE_ECO = 2'd0;
   localparam logic [1:0] MODE_STANDARD = 2'd1;
   localparam logic [1:0] MODE_ULTRA = 2'd2;

   localparam logic OP_RECORD = 1'b0;

   typedef struct packed {
      logic        opcode;
      logic [31:0] oversleep_ticks;
      logic [1:0]  precision_mode;
   } req_type;

   typedef struct packed {
      logic [29:0] margin_ticks;
      logic [30:0] median_ticks;
      logic [30:0] upper_quartile_ticks;
      logic [30:0] high_percentile_ticks;
      logic [30:0] maximum_ticks;
      logic [7:0]  held_count;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_LOAD,
      ST_DRAIN,
      ST_PICK,
      ST_MARGIN,
      ST_OUT
   } state_type;

   // Control from the sequencer to each sort cell.
   typedef struct packed {
      logic clear;
      logic insert;
      logic shift;
   } cell_ctl_type;

   function automatic logic [30:0] floor_zero(input logic [31:0] biased);
      floor_zero = biased[31] ? biased[30:0] : 31'd0;
   endfunction

endpackage

@@ rtl/ospm_cell.sv @@
// One cell of the insertion sort chain, holding one biased sample.
`timescale 1ns / 1ps
module ospm_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  ospm_pkg::cell_ctl_type ctl,
   input  logic [31:0]           new_value,
   input  logic [31:0]           prev_value,
   input  logic                  prev_full,
   input  logic                  prev_takes,
   input  logic [31:0]           next_value,
   output logic [31:0]           value,
   output logic                  full,
   output logic                  takes
);
   logic [31:0] value_ff, value_in;
   logic        full_ff, full_in;
   logic        here_takes;

   // Cells hold ascending values; an empty cell counts as larger than anything.
   assign here_takes = !full_ff || (value_ff > new_value);
   assign takes = here_takes;

   always_comb begin
      value_in = value_ff;
      full_in = full_ff;
      if (ctl.clear) begin
         full_in = 1'b0;
      end else if (ctl.insert && here_takes) begin
         // The first taking cell stores the new value and the cells after it
         // move up by one; empty cells past the end stay empty.
         if (prev_takes && prev_full) begin
            full_in = 1'b1;
            value_in = prev_value;
         end else if (!prev_takes) begin
            full_in = 1'b1;
            value_in = new_value;
         end
      end else if (ctl.shift) begin
         value_in = next_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
      end else begin
         full_ff <= full_in;
      end
      value_ff <= value_in;
   end

   assign value = value_ff;
   assign full = full_ff;
endmodule

@@ rtl/oversleep_percentile_margin.sv @@
// Top level of the oversleep percentile margin estimator.
`timescale 1ns / 1ps
// Samples sit in a ring memory of SAMPLE_DEPTH entries. A request that needs a
// model refresh (every sample while 8 to 31 are held, then every 32nd)
// reads the held samples one per cycle into a chain of SAMPLE_DEPTH sort cells
// that insert in order, then shifts the sorted chain out one cell per cycle to
// catch the percentile ranks. A recorded sample without a refresh and a
// report-only request skip the sort and go straight to the margin step. One
// request is worked at a time; the result sits in an output register until
// taken, and the next request is accepted only after that.
module oversleep_percentile_margin #(
   parameter int SAMPLE_DEPTH = ospm_pkg::DEFAULT_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ospm_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ospm_pkg::rsp_type rsp_data,
   input  logic             csr_write,
   input  logic [1:0]       csr_index,
   input  logic [39:0]      csr_data
);
   localparam int AW = $clog2(SAMPLE_DEPTH);
   localparam int CW = $clog2(SAMPLE_DEPTH + 1);

   ospm_pkg::state_type state_ff, state_in;

   logic [9:0]  tpu_ff;
   logic [30:0] fixed_ff;
   logic [39:0] hint_ff;

   logic [31:0] mem [SAMPLE_DEPTH];
   logic [31:0] rd_ff;
   logic [AW-1:0] wpos_ff, wpos_in;
   logic [CW-1:0] total_ff, total_in;
   logic [5:0]  since_ff, since_in;
   logic [30:0] p50_ff, p50_in, p75_ff, p75_in, p99_ff, p99_in, max_ff, max_in;

   ospm_pkg::req_type req_ff;
   logic        req_take;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] n_ff, n_in;
   logic [AW-1:0] raddr;
   logic        rd_live_ff, rd_live_in;
   logic [CW-1:0] i50_ff, i75_ff, i99_ff;
   logic [CW-1:0] n_less1;
   logic [CW+1:0] n_x3;
   logic [CW+13:0] hund_prod;

   logic [29:0] margin_in;
   ospm_pkg::rsp_type rsp_ff;
   logic        rsp_valid_ff;

   ospm_pkg::cell_ctl_type ctl;
   logic [31:0] cval [SAMPLE_DEPTH];
   logic        cfull [SAMPLE_DEPTH];
   logic        ctake [SAMPLE_DEPTH];

   genvar g;
   generate
      for (g = 0; g < SAMPLE_DEPTH; g++) begin : g_cell
         ospm_cell u_cell (
            .clock(clock), .reset(reset), .ctl(ctl), .new_value(rd_ff),
            .prev_value(g == 0 ? 32'd0 : cval[(g == 0) ? 0 : g - 1]),
            .prev_full(g == 0 ? 1'b0 : cfull[(g == 0) ? 0 : g - 1]),
            .prev_takes(g == 0 ? 1'b0 : ctake[(g == 0) ? 0 : g - 1]),
            .next_value(g == SAMPLE_DEPTH - 1 ? 32'd0
                        : cval[(g == SAMPLE_DEPTH - 1) ? g : g + 1]),
            .value(cval[g]), .full(cfull[g]), .takes(ctake[g])
         );
      end
   endgenerate

   // Scaled constants and margin math.
   logic [21:0] t100, t200, t300, t2500, t3000;
   logic [32:0] want_s, want_u;
   assign t100 = 22'(tpu_ff) * 22'd100;
   assign t200 = 22'(tpu_ff) * 22'd200;
   assign t300 = 22'(tpu_ff) * 22'd300;
   assign t2500 = 22'(tpu_ff) * 22'd2500;
   assign t3000 = 22'(tpu_ff) * 22'd3000;

   // The period hint divided by ten, by shifts and adds over two register stages.
   logic [39:0] hint_a_ff, hint_a_in, hint_div_ff, hint_div_in;
   logic [39:0] hint_s1, hint_s2, hint_s3, hint_s4, hint_q, hint_r;

   always_comb begin
      hint_s1 = (csr_data >> 1) + (csr_data >> 2);
      hint_s2 = hint_s1 + (hint_s1 >> 4);
      hint_a_in = hint_s2 + (hint_s2 >> 8);
      hint_s3 = hint_a_ff + (hint_a_ff >> 16);
      hint_s4 = hint_s3 + (hint_s3 >> 32);
      hint_q = hint_s4 >> 3;
      hint_r = hint_ff - ((hint_q << 3) + (hint_q << 1));
      hint_div_in = (hint_r > 40'd9) ? hint_q + 40'd1 : hint_q;
   end

   always_comb begin
      want_s = 33'(p99_ff) + 33'(t100);
      if (want_s < 33'(t100)) want_s = 33'(t100);
      if (want_s > 33'(t2500)) want_s = 33'(t2500);
      if (hint_ff != 40'd0 && 40'(want_s) > hint_div_ff) want_s = hint_div_ff[32:0];
      want_u = 33'(p99_ff) + 33'(t200);
      if (33'(max_ff) > want_u) want_u = 33'(max_ff);
      if (want_u < 33'(t300)) want_u = 33'(t300);
      if (want_u > 33'(t3000)) want_u = 33'(t3000);
      if (req_ff.precision_mode == ospm_pkg::MODE_ECO) begin
         margin_in = 30'd0;
      end else if (!fixed_ff[30]) begin
         margin_in = fixed_ff[29:0];
      end else if (req_ff.precision_mode == ospm_pkg::MODE_STANDARD) begin
         margin_in = want_s[29:0];
      end else if (req_ff.precision_mode == ospm_pkg::MODE_ULTRA) begin
         margin_in = want_u[29:0];
      end else begin
         margin_in = 30'd0;
      end
   end

   assign req_take = req_valid && !req_stall;
   assign req_stall = (state_ff != ospm_pkg::ST_IDLE) || rsp_valid_ff;
   assign raddr = cnt_ff[AW-1:0];

   // Rank indexes: n/2, (3n-1)/4 and m - (m+49)/100 with m = n-1.
   assign n_less1 = n_ff - 1'b1;
   assign n_x3 = (CW+2)'(n_ff) + ((CW+2)'(n_ff) << 1);
   assign hund_prod = ((CW+14)'(n_less1) + (CW+14)'(49)) * (CW+14)'(5243);

   always_comb begin
      state_in = state_ff;
      wpos_in = wpos_ff;
      total_in = total_ff;
      since_in = since_ff;
      cnt_in = cnt_ff;
      n_in = n_ff;
      rd_live_in = 1'b0;
      p50_in = p50_ff;
      p75_in = p75_ff;
      p99_in = p99_ff;
      max_in = max_ff;
      ctl = '0;
      case (state_ff)
         ospm_pkg::ST_IDLE: begin
            if (req_take) begin
               if (req_data.opcode == ospm_pkg::OP_RECORD) begin
                  wpos_in = (wpos_ff == AW'(SAMPLE_DEPTH - 1)) ? '0 : wpos_ff + 1'b1;
                  if (total_ff < CW'(SAMPLE_DEPTH)) total_in = total_ff + 1'b1;
                  since_in = since_ff + 6'd1;
                  state_in = ospm_pkg::ST_CLEAR;
               end else begin
                  state_in = ospm_pkg::ST_MARGIN;
               end
            end
         end
         ospm_pkg::ST_CLEAR: begin
            if (since_ff >= 6'(ospm_pkg::REFRESH_EVERY) ||
                total_ff < CW'(ospm_pkg::REFRESH_EVERY)) begin
               since_in = 6'd0;
               if (total_ff >= CW'(ospm_pkg::MIN_FOR_MODEL)) begin
                  ctl.clear = 1'b1;
                  n_in = total_ff;
                  cnt_in = '0;
                  state_in = ospm_pkg::ST_LOAD;
               end else begin
                  state_in = ospm_pkg::ST_MARGIN;
               end
            end else begin
               state_in = ospm_pkg::ST_MARGIN;
            end
         end
         ospm_pkg::ST_LOAD: begin
            // Read address cnt_ff; data of the previous read is inserted.
            ctl.insert = rd_live_ff;
            if (cnt_ff == n_ff) begin
               state_in = ospm_pkg::ST_DRAIN;
            end else begin
               rd_live_in = 1'b1;
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ospm_pkg::ST_DRAIN: begin
            ctl.insert = rd_live_ff;
            cnt_in = '0;
            state_in = ospm_pkg::ST_PICK;
         end
         ospm_pkg::ST_PICK: begin
            // Cell 0 shows rank cnt_ff.
            if (cnt_ff == i50_ff) p50_in = ospm_pkg::floor_zero(cval[0]);
            if (cnt_ff == i75_ff) p75_in = ospm_pkg::floor_zero(cval[0]);
            if (cnt_ff == i99_ff) p99_in = ospm_pkg::floor_zero(cval[0]);
            if (cnt_ff == n_ff - 1'b1) begin
               max_in = ospm_pkg::floor_zero(cval[0]);
               state_in = ospm_pkg::ST_MARGIN;
            end else begin
               ctl.shift = 1'b1;
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ospm_pkg::ST_MARGIN: begin
            state_in = ospm_pkg::ST_OUT;
         end
         ospm_pkg::ST_OUT: begin
            state_in = ospm_pkg::ST_IDLE;
         end
         default: begin
            state_in = ospm_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ospm_pkg::ST_IDLE;
         tpu_ff <= 10'd10;
         fixed_ff <= 31'h7FFF_FFFF;
         hint_ff <= 40'd0;
         hint_a_ff <= 40'd0;
         hint_div_ff <= 40'd0;
         wpos_ff <= '0;
         total_ff <= '0;
         since_ff <= 6'd0;
         p50_ff <= 31'd2500;
         p75_ff <= 31'd4000;
         p99_ff <= 31'd6000;
         max_ff <= 31'd10000;
         rsp_valid_ff <= 1'b0;
         rd_live_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         wpos_ff <= wpos_in;
         total_ff <= total_in;
         since_ff <= since_in;
         p50_ff <= p50_in;
         p75_ff <= p75_in;
         p99_ff <= p99_in;
         max_ff <= max_in;
         rd_live_ff <= rd_live_in;
         hint_div_ff <= hint_div_in;
         if (csr_write) begin
            case (csr_index)
               ospm_pkg::CSR_TICKS_PER_US: tpu_ff <= csr_data[9:0];
               ospm_pkg::CSR_FIXED_MARGIN: fixed_ff <= csr_data[30:0];
               ospm_pkg::CSR_PERIOD_HINT: begin
                  hint_ff <= csr_data;
                  hint_a_ff <= hint_a_in;
               end
               default: begin
               end
            endcase
         end
         if (state_ff == ospm_pkg::ST_OUT) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      n_ff <= n_in;
      rd_ff <= mem[raddr];
      if (state_ff == ospm_pkg::ST_IDLE && req_take) begin
         req_ff <= req_data;
         if (req_data.opcode == ospm_pkg::OP_RECORD) begin
            mem[wpos_ff] <= req_data.oversleep_ticks ^ ospm_pkg::SIGN_BIAS;
         end
      end
      if (state_ff == ospm_pkg::ST_LOAD && cnt_ff == '0) begin
         i50_ff <= n_ff >> 1;
         i75_ff <= CW'((n_x3 - 1'b1) >> 2);
         i99_ff <= n_less1 - CW'(hund_prod >> 19);
      end
      if (state_ff == ospm_pkg::ST_OUT) begin
         rsp_ff.margin_ticks <= margin_in;
         rsp_ff.median_ticks <= p50_ff;
         rsp_ff.upper_quartile_ticks <= p75_ff;
         rsp_ff.high_percentile_ticks <= p99_ff;
         rsp_ff.maximum_ticks <= max_ff;
         rsp_ff.held_count <= 8'(total_ff);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;
endmodule
